// ----- rtl/mjdc_pkg.sv -----
// ----------------------------------------------------------------------------
// mjdc_pkg
// Shared types, widths and constant tables for the MJD to calendar converter.
// ----------------------------------------------------------------------------
package mjdc_pkg;

  // width of the whole-day count
  localparam int DAY_BITS = 20;

  // pipeline depth, one valid bit per stage
  localparam int NUM_STAGES = 5;

  // output field widths
  localparam int YEAR_W = 13;
  localparam int MON_W  = 4;
  localparam int DOM_W  = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int SFR_W  = 16;
  localparam int FRAC_W = 32;

  // b = mjd_day + 2400001 + 1537
  localparam longint unsigned B_OFFSET = 64'd2401538;
  localparam longint unsigned B_MAX    = ((64'd1 << DAY_BITS) - 64'd1) + B_OFFSET;
  localparam int B_W = $clog2(B_MAX + 64'd1);

  // n = 100*b - 12210, divided by 36525 to get c
  localparam longint unsigned N_MAX = 64'd100 * B_MAX;
  localparam int N_W = $clog2(N_MAX + 64'd1);
  localparam longint unsigned C_DIV = 64'd36525;
  localparam longint unsigned C_MAX = (N_MAX - 64'd12210) / C_DIV;
  localparam int C_W = $clog2(C_MAX + 64'd1);

  // reciprocal of 36525 scaled by 2^N_W, estimate is low by at most one
  localparam longint unsigned C_RECIP = (64'd1 << N_W) / C_DIV;
  localparam int RC_W = $clog2(C_RECIP + 64'd1);

  // b - floor(365.25*c) always lies in 123..488
  localparam int BD_W = 9;
  localparam int E_W  = 4;

  // ceil(30.6001*k): bd at or above this gives e >= k
  localparam logic [BD_W-1:0] E_THRESH [1:15] = '{
    9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
    9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
  };

  // floor(30.6001*e)
  localparam logic [BD_W-1:0] E_FLOOR [0:15] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // transaction payloads
  typedef struct packed {
    logic [DAY_BITS-1:0] mjd_day;
    logic [FRAC_W-1:0]   day_fraction;
  } in_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day_of_month;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second_whole;
    logic [SFR_W-1:0]  second_fraction;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day_of_month;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second_whole;
    logic [SFR_W-1:0]  second_fraction;
  } out_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctl_t;

  // month index e = floor(bd / 30.6001)
  function automatic logic [E_W-1:0] month_index(input logic [BD_W-1:0] bd);
    logic [E_W-1:0] e;
    e = '0;
    for (int k = 1; k <= 15; k++) begin
      if (bd >= E_THRESH[k]) begin
        e = E_W'(k);
      end
    end
    return e;
  endfunction

endpackage

// ----- rtl/mjdc_date_path.sv -----
// ----------------------------------------------------------------------------
// mjdc_date_path
// Five-stage datapath from the whole-day count to year, month and day.
// ----------------------------------------------------------------------------
module mjdc_date_path import mjdc_pkg::*; (
  input  logic                clk,
  input  stage_ctl_t          ctl,
  input  logic [DAY_BITS-1:0] mjd_day,
  output date_t               date
);

  localparam logic [N_W-1:0]   K100     = N_W'(100);
  localparam logic [N_W-1:0]   K12210   = N_W'(12210);
  localparam logic [B_W-1:0]   KBOFF    = B_W'(B_OFFSET);
  localparam logic [RC_W-1:0]  KRECIP   = RC_W'(C_RECIP);
  localparam logic [N_W:0]     KCDIV    = (N_W+1)'(C_DIV);
  localparam logic [B_W+1:0]   K1461    = (B_W+2)'(1461);
  localparam logic [YEAR_W-1:0] K4715   = YEAR_W'(4715);

  // stage 1: b and scaled numerator
  logic [B_W-1:0] b1_r, b1_nxt;
  logic [N_W-1:0] n1_r, n1_nxt;

  always_comb begin
    b1_nxt = B_W'(mjd_day) + KBOFF;
    n1_nxt = N_W'(N_W'(b1_nxt) * K100) - K12210;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      b1_r <= b1_nxt;
      n1_r <= n1_nxt;
    end
  end

  // stage 2: reciprocal estimate of n / 36525
  logic [B_W-1:0]      b2_r;
  logic [N_W-1:0]      n2_r;
  logic [C_W-1:0]      q2_r, q2_nxt;
  logic [N_W+RC_W-1:0] prod2;

  always_comb begin
    prod2  = (N_W+RC_W)'(n1_r) * (N_W+RC_W)'(KRECIP);
    q2_nxt = C_W'(prod2 >> N_W);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      b2_r <= b1_r;
      n2_r <= n1_r;
      q2_r <= q2_nxt;
    end
  end

  // stage 3: correct the estimate by one compare
  logic [B_W-1:0] b3_r;
  logic [C_W-1:0] c3_r, c3_nxt;
  logic [N_W:0]   rem3;

  always_comb begin
    rem3   = (N_W+1)'(n2_r) - (N_W+1)'((N_W+1)'(q2_r) * KCDIV);
    c3_nxt = (rem3 >= KCDIV) ? C_W'(q2_r + C_W'(1)) : q2_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      b3_r <= b2_r;
      c3_r <= c3_nxt;
    end
  end

  // stage 4: day within the shifted year, bd = b - floor(1461*c/4)
  logic [C_W-1:0]  c4_r;
  logic [BD_W-1:0] bd4_r, bd4_nxt;
  logic [B_W+1:0]  d4x;

  always_comb begin
    d4x     = (B_W+2)'((B_W+2)'(c3_r) * K1461);
    bd4_nxt = BD_W'(b3_r - B_W'(d4x >> 2));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      c4_r  <= c3_r;
      bd4_r <= bd4_nxt;
    end
  end

  // stage 5: month index, day of month, month and year
  date_t          date_r, date_nxt;
  logic [E_W-1:0] e5;
  logic [MON_W-1:0] mon5;

  always_comb begin
    e5   = month_index(bd4_r);
    mon5 = (e5 < E_W'(14)) ? MON_W'(e5 - E_W'(1)) : MON_W'(e5 - E_W'(13));
    date_nxt.day_of_month = DOM_W'(bd4_r - E_FLOOR[e5]);
    date_nxt.month        = mon5;
    date_nxt.year         = YEAR_W'(c4_r) - K4715 - YEAR_W'(mon5 > MON_W'(2));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

// ----- rtl/mjdc_time_path.sv -----
// ----------------------------------------------------------------------------
// mjdc_time_path
// Five-stage datapath from the day fraction to hour, minute and second.
// ----------------------------------------------------------------------------
module mjdc_time_path import mjdc_pkg::*; (
  input  logic              clk,
  input  stage_ctl_t        ctl,
  input  logic [FRAC_W-1:0] day_fraction,
  output tod_t              tod
);

  // stage 1: scale by 24, integer part is the hour
  logic [FRAC_W+4:0]  p1;
  logic [HOUR_W-1:0]  hr1_r;
  logic [FRAC_W-1:0]  f1_r;

  assign p1 = (FRAC_W+5)'(day_fraction) * (FRAC_W+5)'(24);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      hr1_r <= p1[FRAC_W+4:FRAC_W];
      f1_r  <= p1[FRAC_W-1:0];
    end
  end

  // stage 2: scale by 60, integer part is the minute
  logic [FRAC_W+5:0] p2;
  logic [HOUR_W-1:0] hr2_r;
  logic [MIN_W-1:0]  mi2_r;
  logic [FRAC_W-1:0] f2_r;

  assign p2 = (FRAC_W+6)'(f1_r) * (FRAC_W+6)'(60);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      hr2_r <= hr1_r;
      mi2_r <= p2[FRAC_W+5:FRAC_W];
      f2_r  <= p2[FRAC_W-1:0];
    end
  end

  // stage 3: scale by 60, whole seconds and truncated fraction
  logic [FRAC_W+5:0] p3;
  tod_t              tod3_r, tod3_nxt;

  always_comb begin
    p3                       = (FRAC_W+6)'(f2_r) * (FRAC_W+6)'(60);
    tod3_nxt.hour            = hr2_r;
    tod3_nxt.minute          = mi2_r;
    tod3_nxt.second_whole    = p3[FRAC_W+5:FRAC_W];
    tod3_nxt.second_fraction = p3[FRAC_W-1:FRAC_W-SFR_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      tod3_r <= tod3_nxt;
    end
  end

  // stages 4 and 5: keep alignment with the date path
  tod_t tod4_r, tod5_r;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      tod4_r <= tod3_r;
    end
    if (ctl.load[4]) begin
      tod5_r <= tod4_r;
    end
  end

  assign tod = tod5_r;

endmodule

// ----- rtl/mjd_to_calendar_date_unit.sv -----
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_unit
// Modified Julian Date and Q0.32 day fraction to Gregorian date and time.
// ----------------------------------------------------------------------------
// A five-stage pipeline that accepts one timestamp transaction per cycle when
// the input does not stall. The result is presented on the output from the
// last stage and is taken when the output side does not stall. The depth
// is set by the chain of the date path: day offset and scaling, a reciprocal
// multiply for the division by 36525, a one-step correction, the 365.25 day
// product and the month lookup; the time of day uses three multiplies by 24,
// 60 and 60 in stages beside the date path. Each stage has its own valid bit
// and loads whenever it is empty or the next stage moves, so bubbles are
// squeezed out and the input keeps flowing while a finished result waits in
// the output register; the input stalls only when all five stages hold a
// transaction and the output is stalled. No reset of datapath registers and
// no configuration.
module mjd_to_calendar_date_unit import mjdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // per-stage valid bits and ready chain
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES:0]   rdy;
  stage_ctl_t            ctl;

  always_comb begin
    rdy[NUM_STAGES] = !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ctl.load = rdy[NUM_STAGES-1:0];
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end else begin
      vld_nxt[0] = vld_r[0];
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // date and time datapaths
  date_t date;
  tod_t  tod;

  mjdc_date_path u_date (
    .clk     (clk),
    .ctl     (ctl),
    .mjd_day (in_data.mjd_day),
    .date    (date)
  );

  mjdc_time_path u_time (
    .clk          (clk),
    .ctl          (ctl),
    .day_fraction (in_data.day_fraction),
    .tod          (tod)
  );

  // result transaction
  always_comb begin
    out_data.year            = date.year;
    out_data.month           = date.month;
    out_data.day_of_month    = date.day_of_month;
    out_data.hour            = tod.hour;
    out_data.minute          = tod.minute;
    out_data.second_whole    = tod.second_whole;
    out_data.second_fraction = tod.second_fraction;
  end

  // accepted transaction lands in the first stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction not captured in first stage");

  // the stage before the last keeps its valid bit when the last stage cannot move
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STAGES-2] && !rdy[NUM_STAGES-1] |=> vld_r[NUM_STAGES-2])
    else $error("stalled stage lost its transaction");

  // month and day of month stay in calendar range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.month >= MON_W'(1) && out_data.month <= MON_W'(12) &&
                  out_data.day_of_month != '0)
    else $error("date field out of range");

  // time of day fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hour <= HOUR_W'(23) && out_data.minute <= MIN_W'(59) &&
                  out_data.second_whole <= SEC_W'(59))
    else $error("time field out of range");

endmodule

// ----- verif/mjd_to_calendar_date_unit_test.sv -----
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_unit_test
// Self-checking testbench for the MJD to Gregorian date and time converter.
// ----------------------------------------------------------------------------
// A directed set of timestamps comes first: the field extremes, leap days,
// year and month ends, hour and second edges and alternating bit patterns.
// Random timestamps follow over several traffic mixes: no idling, a sparse
// sender, a stalling receiver and both at once. One receiver hold-off fills
// the pipeline and backs up the input, and one sender pause lets everything
// drain. A scoreboard computes the calendar fields of each accepted input
// and compares every result transaction against the oldest expectation.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mjdc_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 920;

  // expected calendar results of accepted timestamps, oldest first
  class calendar_scoreboard;
    out_t expected_q[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // date by the fixed-offset algorithm, time by repeated fixed-point scaling
    function out_t to_calendar(in_t ts);
      longint unsigned b, c, d, bd, e, dom, mon, yr, frac, prod;
      out_t r;
      b   = 64'(ts.mjd_day) + 64'd2401538;
      c   = (64'd100 * b - 64'd12210) / 64'd36525;
      d   = (64'd1461 * c) / 64'd4;
      bd  = b - d;
      e   = (64'd10000 * bd) / 64'd306001;
      dom = bd - (64'd306001 * e) / 64'd10000;
      mon = e - 64'd1 - 64'd12 * (e / 64'd14);
      yr  = c - 64'd4715 - (64'd7 + mon) / 64'd10;
      r.year         = YEAR_W'(yr);
      r.month        = MON_W'(mon);
      r.day_of_month = DOM_W'(dom);
      // keep the integer part at each step, carry the fraction on
      prod     = 64'(ts.day_fraction) * 64'd24;
      r.hour   = HOUR_W'(prod >> 32);
      frac     = prod & 64'hFFFF_FFFF;
      prod     = frac * 64'd60;
      r.minute = MIN_W'(prod >> 32);
      frac     = prod & 64'hFFFF_FFFF;
      prod     = frac * 64'd60;
      r.second_whole    = SEC_W'(prod >> 32);
      frac              = prod & 64'hFFFF_FFFF;
      r.second_fraction = SFR_W'(frac >> 16);
      return r;
    endfunction

    function void note_input(in_t ts);
      expected_q.push_back(to_calendar(ts));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $error("result transaction with nothing outstanding: %h", got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("year", 32'(want.year), 32'(got.year));
      compare_field("month", 32'(want.month), 32'(got.month));
      compare_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
      compare_field("hour", 32'(want.hour), 32'(got.hour));
      compare_field("minute", 32'(want.minute), 32'(got.minute));
      compare_field("second_whole", 32'(want.second_whole), 32'(got.second_whole));
      compare_field("second_fraction", 32'(want.second_fraction),
                    32'(got.second_fraction));
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  calendar_scoreboard sb = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_req        = 1'b0;
  int quiet_cycles    = 0;

  mjd_to_calendar_date_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: check accepted results, then pick the next stall value
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one timestamp after a random gap and wait until it is taken
  task automatic send_timestamp(in_t ts);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= in_t'({DAY_BITS'($urandom), FRAC_W'($urandom)});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ts;
    do @(posedge clk); while (in_stall);
    sb.note_input(ts);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic in_t random_timestamp();
    in_t ts;
    // a quarter of the days fall in the recent century
    if ($urandom_range(3) == 0) begin
      ts.mjd_day = DAY_BITS'($urandom_range(70000, 40000));
    end else begin
      ts.mjd_day = DAY_BITS'($urandom);
    end
    // some fractions sit at the start or end of the day
    case ($urandom_range(7))
      0:       ts.day_fraction = 32'hFFFF_FFFF - 32'($urandom_range(255));
      1:       ts.day_fraction = 32'($urandom_range(255));
      default: ts.day_fraction = $urandom;
    endcase
    return ts;
  endfunction

  task automatic random_phase(int idle_pct, int stall_pct, int count);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) send_timestamp(random_timestamp());
  endtask

  // stimulus and end of run
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed timestamps
    send_timestamp(in_t'{20'd0, 32'h0000_0000});
    send_timestamp(in_t'{20'hF_FFFF, 32'hFFFF_FFFF});
    send_timestamp(in_t'{20'd0, 32'hFFFF_FFFF});
    send_timestamp(in_t'{20'hF_FFFF, 32'h0000_0000});
    send_timestamp(in_t'{20'd1, 32'h0000_0001});
    send_timestamp(in_t'{20'd51543, 32'hFFFF_FFFF});
    send_timestamp(in_t'{20'd51544, 32'h8000_0000});
    send_timestamp(in_t'{20'd51574, 32'h4000_0000});
    send_timestamp(in_t'{20'd51575, 32'hC000_0000});
    send_timestamp(in_t'{20'd51603, 32'h0000_0000});
    send_timestamp(in_t'{20'd51604, 32'h0000_0000});
    send_timestamp(in_t'{20'd15078, 32'h0AAA_AAAA});
    send_timestamp(in_t'{20'd15079, 32'h0AAA_AAAB});
    send_timestamp(in_t'{20'd88068, 32'hFFFF_0000});
    send_timestamp(in_t'{20'd59945, 32'h0000_FFFF});
    send_timestamp(in_t'{20'hA_AAAA, 32'hAAAA_AAAA});
    send_timestamp(in_t'{20'h5_5555, 32'h5555_5555});
    send_timestamp(in_t'{20'd60309, 32'h002D_82D8});
    send_timestamp(in_t'{20'd60310, 32'h002D_82D9});
    send_timestamp(in_t'{20'hF_FFFE, 32'hFFFF_FF00});

    random_phase(0, 0, RANDOM_ITEMS / 4);
    random_phase(64, 0, RANDOM_ITEMS / 4);
    random_phase(0, 64, RANDOM_ITEMS / 4);
    random_phase(38, 38, RANDOM_ITEMS / 4);

    // long receiver hold-off while the sender keeps pushing
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b1;
    repeat (50) send_timestamp(random_timestamp());

    // sender pause until the pipeline is empty, then a last burst
    drain_results();
    random_phase(38, 38, 50);

    drain_results();
    repeat (3 * NUM_STAGES + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mjdc_pkg.sv
rtl/mjdc_date_path.sv
rtl/mjdc_time_path.sv
rtl/mjd_to_calendar_date_unit.sv
verif/mjd_to_calendar_date_unit_test.sv
